// ----- rtl/log_record_crc_checker_assert.svh -----
// ----------------------------------------------------------------------------
// Log record CRC checker assertion macros
// Concurrent assertion wrappers used by the checker's top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef LOG_RECORD_CRC_CHECKER_ASSERT_SVH
`define LOG_RECORD_CRC_CHECKER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define LRCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define LRCC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/lrcc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Log record CRC checker package
// Record format constants, status codes and the CRC-32 matrix built at
// elaboration.
// ----------------------------------------------------------------------------
package lrcc_pkg;

  localparam int unsigned KeyBits     = 64;
  localparam int unsigned ValueBits   = 64;
  localparam int unsigned CheckBits   = 32;
  localparam int unsigned PresentBits = 5;
  localparam int unsigned LenBits     = 32;
  localparam int unsigned DataBits    = KeyBits + ValueBits;

  localparam logic [CheckBits-1:0]   CrcPoly     = 32'hEDB8_8320;
  localparam logic [CheckBits-1:0]   CrcInit     = 32'hFFFF_FFFF;
  localparam logic [PresentBits-1:0] RecordBytes = 5'd20;
  localparam logic [LenBits-1:0]     RecordLen   = 32'd20;

  typedef enum logic [1:0] {
    StValid    = 2'd0,
    StMismatch = 2'd1,
    StPartial  = 2'd2,
    StIgnored  = 2'd3
  } status_e;

  // One row per CRC bit: the data bits that feed it.
  typedef logic [CheckBits-1:0][DataBits-1:0] crc_mat_t;

  typedef struct packed {
    status_e               status;
    logic [KeyBits-1:0]    key;
    logic [ValueBits-1:0]  value;
    logic [LenBits-1:0]    length;
    logic                  stopped;
  } scan_res_t;

  // Bit-serial reflected CRC; used only to derive constants.
  function automatic logic [CheckBits-1:0] crc_serial(
    input logic [DataBits-1:0]  data,
    input logic [CheckBits-1:0] init
  );
    logic [CheckBits-1:0] crc;
    logic                 fb;
    crc = init;
    for (int b = 0; b < DataBits; b++) begin
      fb  = crc[0] ^ data[b];
      crc = crc >> 1;
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  function automatic crc_mat_t crc_matrix();
    crc_mat_t             m;
    logic [CheckBits-1:0] col;
    logic [DataBits-1:0]  unit;
    m = '0;
    for (int i = 0; i < DataBits; i++) begin
      unit = '0;
      unit[i] = 1'b1;
      col = crc_serial(unit, '0);
      for (int j = 0; j < CheckBits; j++) begin
        m[j][i] = col[j];
      end
    end
    return m;
  endfunction

  // Contribution of the initial value and the final inversion.
  function automatic logic [CheckBits-1:0] crc_offset();
    return crc_serial('0, CrcInit) ^ CrcInit;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/lrcc_crc.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Log record CRC-32 unit
// CRC-32 over the key and value bytes as one XOR tree per result bit.
// ----------------------------------------------------------------------------
module lrcc_crc (
  input  logic [lrcc_pkg::KeyBits-1:0]   key_i,
  input  logic [lrcc_pkg::ValueBits-1:0] value_i,
  output logic [lrcc_pkg::CheckBits-1:0] crc_o
);
  import lrcc_pkg::*;

  localparam crc_mat_t             CrcMat = crc_matrix();
  localparam logic [CheckBits-1:0] CrcOff = crc_offset();

  logic [DataBits-1:0] data;

  // Key bytes go in first, least significant bit of each byte first.
  assign data = {value_i, key_i};

  always_comb begin
    for (int j = 0; j < CheckBits; j++) begin
      crc_o[j] = CrcOff[j] ^ (^(data & CrcMat[j]));
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lrcc_scan.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Log record scan state
// Classifies each record and keeps the stop flag and the valid byte count.
// ----------------------------------------------------------------------------
module lrcc_scan #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [lrcc_pkg::KeyBits-1:0]     key_i,
  input  logic [lrcc_pkg::ValueBits-1:0]   value_i,
  input  logic [lrcc_pkg::CheckBits-1:0]   stored_i,
  input  logic [lrcc_pkg::PresentBits-1:0] present_i,
  input  logic [lrcc_pkg::CheckBits-1:0]   crc_i,
  output lrcc_pkg::scan_res_t              res_o
);
  import lrcc_pkg::*;

  localparam logic [63:0] LimWide = (LENGTH_BITS >= 32) ? 64'h0000_0000_FFFF_FFFF :
                                    ((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [LenBits-1:0] LengthLimit = LimWide[LenBits-1:0];

  logic               stopped_q, stopped_d;
  logic [LenBits-1:0] good_q, good_d;
  logic [LenBits-1:0] good_inc;

  assign good_inc = ((good_q >= LengthLimit) || ((LengthLimit - good_q) < RecordLen)) ?
                    LengthLimit : good_q + RecordLen;

  always_comb begin
    stopped_d     = stopped_q;
    good_d        = good_q;
    res_o.status  = StValid;
    res_o.key     = '0;
    res_o.value   = '0;
    if (stopped_q) begin
      res_o.status = StIgnored;
    end else if (present_i < RecordBytes) begin
      res_o.status = StPartial;
      stopped_d    = 1'b1;
    end else if (crc_i != stored_i) begin
      res_o.status = StMismatch;
      stopped_d    = 1'b1;
    end else begin
      res_o.key   = key_i;
      res_o.value = value_i;
      good_d      = good_inc;
    end
    res_o.length  = good_d;
    res_o.stopped = stopped_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b0;
      good_q    <= '0;
    end else if (step_i) begin
      stopped_q <= stopped_d;
      good_q    <= good_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/log_record_crc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Log record CRC checker
// Scans 20-byte log records, checks their CRC-32 and reports the valid
// prefix length.
// ----------------------------------------------------------------------------
// Input channel: one record per transfer (key, value, stored CRC and the
// number of bytes present). Output channel: one result per record (status,
// key and value of a valid record, valid prefix length so far).
// A record is held in the input register, checked by the combinational XOR
// trees and a compare, and the result is loaded into the output register.
// The result is offered once the record has passed the input register and
// the output register. One record is taken every cycle while the receiver
// keeps ready high, since the CRC trees are combinational.
// When the receiver stalls, the result holds in the output register and the
// input register still takes one more record; after that ready drops until
// the output register is freed.
// Reset empties both registers and starts a new scan: the stop flag clears
// and the valid length returns to zero. After a mismatch or a partial record
// every later record is reported as ignored until the next reset.
// ----------------------------------------------------------------------------
`include "log_record_crc_checker_assert.svh"

module log_record_crc_checker #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [lrcc_pkg::KeyBits-1:0]     rec_key_i,
  input  logic [lrcc_pkg::ValueBits-1:0]   rec_value_i,
  input  logic [lrcc_pkg::CheckBits-1:0]   stored_check_i,
  input  logic [lrcc_pkg::PresentBits-1:0] bytes_present_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [1:0]                       status_o,
  output logic [lrcc_pkg::KeyBits-1:0]     out_key_o,
  output logic [lrcc_pkg::ValueBits-1:0]   out_value_o,
  output logic [lrcc_pkg::LenBits-1:0]     valid_length_o
);
  import lrcc_pkg::*;

  localparam logic [63:0] LimWide = (LENGTH_BITS >= 32) ? 64'h0000_0000_FFFF_FFFF :
                                    ((64'd1 << LENGTH_BITS) - 64'd1);
  localparam logic [LenBits-1:0] LengthLimit = LimWide[LenBits-1:0];

  logic                   s1_vld_q;
  logic [KeyBits-1:0]     s1_key_q;
  logic [ValueBits-1:0]   s1_value_q;
  logic [CheckBits-1:0]   s1_check_q;
  logic [PresentBits-1:0] s1_present_q;

  logic                   out_vld_q;
  scan_res_t              out_res_q;

  logic                   advance;
  logic                   in_fire;
  logic                   step;
  logic [CheckBits-1:0]   crc;
  scan_res_t              res;

  // The output register frees up when empty or when its transfer completes.
  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !s1_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign step       = s1_vld_q && advance;

  lrcc_crc u_crc (
    .key_i   (s1_key_q),
    .value_i (s1_value_q),
    .crc_o   (crc)
  );

  lrcc_scan #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .key_i     (s1_key_q),
    .value_i   (s1_value_q),
    .stored_i  (s1_check_q),
    .present_i (s1_present_q),
    .crc_i     (crc),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q     <= rec_key_i;
      s1_value_q   <= rec_value_i;
      s1_check_q   <= stored_check_i;
      s1_present_q <= bytes_present_i;
    end
    if (step) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_o       = out_res_q.status;
  assign out_key_o      = out_res_q.key;
  assign out_value_o    = out_res_q.value;
  assign valid_length_o = out_res_q.length;

  // Once stopped, the scan stays stopped until reset.
  `LRCC_ASSERT(a_stop_sticky, res.stopped |=> res.stopped, "scan stop flag cleared")

  // A short record seen while scanning is reported as partial.
  `LRCC_ASSERT(a_partial_reported,
               step && !res.stopped && (s1_present_q < RecordBytes) |=>
               out_valid_o && (out_res_q.status == StPartial),
               "short record not reported as partial")

  // Only a valid record carries its key and value.
  `LRCC_ASSERT(a_payload_zero,
               out_valid_o && (out_res_q.status != StValid) |->
               (out_key_o == '0) && (out_value_o == '0),
               "payload of a rejected record is not zero")

  // The reported length never passes the saturation limit.
  `LRCC_ASSERT_ALWAYS(a_length_limit,
                      out_valid_o |-> (valid_length_o <= LengthLimit),
                      "valid length beyond its limit")

endmodule
`default_nettype wire
